/* sv/kmsm_pkg.sv */
// Package for the k-mismatch string matcher.
// Sizes, field widths and codes shared by the matcher RTL; no dependencies.
package kmsm_pkg;

    // Pattern storage and alignment lanes
    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int BYTE_W      = 8;

    // Per-alignment mismatch counter; a lane never exceeds MAX_PATTERN
    localparam int CNT_W   = 7;
    localparam int LEN_W   = 7;
    localparam int TOTAL_W = 32;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Request kinds
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // Register select (word address bit)
    localparam logic REG_LENGTH   = 1'b0;
    localparam logic REG_MAX_MISM = 1'b1;

endpackage

/* sv/k_mismatch_string_matcher.sv */
// k-mismatch string matcher: each input beat passes through the input register,
// then the shift-add update into the result register.
// Throughput one beat per cycle while the output is not stalled; every lane counter updates in parallel.
// Reset (i_rst_n low, synchronous) clears counters, position, count, max
// mismatches and both valid flags and sets the length to one; pattern bytes
// stay undefined until written. Depends on kmsm_pkg.
module k_mismatch_string_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] pattern_index, [13:6] data_byte, [15:14] zero
    input  logic [kmsm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type, [1] first_of_text
    input  logic [kmsm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] window_mismatches, [38:7] match_total, [39] zero
    output logic [kmsm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] match
    output logic [kmsm_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kmsm_pkg::APB_AW-1:0]     paddr,
    input  logic [kmsm_pkg::APB_DW-1:0]     pwdata,
    output logic [kmsm_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int NP = kmsm_pkg::MAX_PATTERN;
    localparam int CW = kmsm_pkg::CNT_W;
    localparam int LW = kmsm_pkg::LEN_W;
    localparam int TW = kmsm_pkg::TOTAL_W;
    localparam int XW = kmsm_pkg::IDX_W;
    localparam int BW = kmsm_pkg::BYTE_W;

    // Config registers
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_max;

    // Input register
    logic          r_in_valid;
    logic          r_in_req;
    logic          r_in_first;
    logic [XW-1:0] r_in_idx;
    logic [BW-1:0] r_in_byte;

    // Matcher state
    logic [BW-1:0] r_pat [NP];
    logic [CW-1:0] r_cnt [NP];
    logic [CW-1:0] n_cnt [NP];
    logic [LW-1:0] r_pos;
    logic [LW-1:0] n_pos;
    logic [TW-1:0] r_total;
    logic [TW-1:0] n_total;

    // Result register
    logic          r_out_valid;
    logic          r_out_match;
    logic [CW-1:0] r_out_mism;
    logic [TW-1:0] r_out_total;
    logic          n_match;
    logic [CW-1:0] n_mism;

    logic          w_out_ready;
    logic          w_go;
    logic          w_text;
    logic [LW-1:0] w_m;
    logic [XW-1:0] w_m_idx;
    logic [CW-1:0] w_sel;
    logic          w_full;
    logic          w_hit;
    logic          w_cfg_wr;

    // Handshake: input register refills whenever it is empty or its beat moves on
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_go          = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_go;
    assign w_text        = (r_in_req == kmsm_pkg::REQ_TEXT);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_total, r_out_mism};
    assign m_axis_tuser  = r_out_match;

    // APB: zero-wait writes and reads
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            kmsm_pkg::REG_LENGTH:   prdata = {{(kmsm_pkg::APB_DW-LW){1'b0}}, r_len};
            kmsm_pkg::REG_MAX_MISM: prdata = {{(kmsm_pkg::APB_DW-LW){1'b0}}, r_max};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LW'(1);
            r_max <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                kmsm_pkg::REG_LENGTH:   r_len <= pwdata[LW-1:0];
                kmsm_pkg::REG_MAX_MISM: r_max <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length: zero acts as one, clamp at the lane count
    always_comb begin
        if (r_len == '0) begin
            w_m = LW'(1);
        end else if (r_len > LW'(NP)) begin
            w_m = LW'(NP);
        end else begin
            w_m = r_len;
        end
    end
    assign w_m_idx = XW'(w_m - LW'(1));

    // Shift-add across all lanes; a new text starts from cleared counters.
    // Lane j holds at most j+1 mismatches, so no saturation is needed.
    always_comb begin
        n_cnt[0] = CW'(r_pat[0] != r_in_byte);
        for (int j = 1; j < NP; j++) begin
            n_cnt[j] = (r_in_first ? CW'(0) : r_cnt[j-1])
                     + CW'(r_pat[j] != r_in_byte);
        end
    end

    // Text position, saturating at the lane count
    always_comb begin
        n_pos = r_in_first ? LW'(0) : r_pos;
        if (n_pos < LW'(NP)) begin
            n_pos = n_pos + LW'(1);
        end
    end

    // Judge the window ending at this byte
    assign w_sel  = n_cnt[w_m_idx];
    assign w_full = (n_pos >= w_m);
    assign w_hit  = w_full && (w_sel <= r_max);

    always_comb begin
        n_total = r_in_first ? TW'(0) : r_total;
        if (w_hit && (n_total != {TW{1'b1}})) begin
            n_total = n_total + TW'(1);
        end
    end

    // Shown count: the counter when it matches, else max plus one (fits, < 65)
    always_comb begin
        n_match = 1'b0;
        n_mism  = '0;
        if (w_full) begin
            n_match = w_hit;
            n_mism  = w_hit ? w_sel : (r_max + LW'(1));
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req   <= s_axis_tuser[0];
            r_in_first <= s_axis_tuser[1];
            r_in_idx   <= s_axis_tdata[XW-1:0];
            r_in_byte  <= s_axis_tdata[XW+BW-1:XW];
        end
    end

    // Pattern bytes: written by index, no reset
    always_ff @(posedge i_clk) begin
        if (w_go && !w_text) begin
            r_pat[r_in_idx] <= r_in_byte;
        end
    end

    // Counter bank, position and running count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NP; j++) begin
                r_cnt[j] <= '0;
            end
            r_pos   <= '0;
            r_total <= '0;
        end else if (w_go && w_text) begin
            for (int j = 0; j < NP; j++) begin
                r_cnt[j] <= n_cnt[j];
            end
            r_pos   <= n_pos;
            r_total <= n_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if (w_text) begin
                r_out_match <= n_match;
                r_out_mism  <= n_mism;
                r_out_total <= n_total;
            end else begin
                r_out_match <= 1'b0;
                r_out_mism  <= '0;
                r_out_total <= r_total;
            end
        end
    end

endmodule
